// ===== rtl/tos_pkg.sv =====
`timescale 1ns / 1ps

package tos_pkg;

   // Header buffer geometry.
   localparam int BUFFER_DEPTH = 64;
   localparam int BUF_AW       = $clog2(BUFFER_DEPTH);
   localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);

   // Result count limits.
   localparam int MAX_RESULTS  = 64;
   localparam int LIM_W        = $clog2(MAX_RESULTS + 1);

   // Fixed header layout.
   localparam int HDR_MIN_LEN  = 20;
   localparam int DOFF_IDX     = 12;
   localparam int CKSUM_HI_IDX = 16;
   localparam int CKSUM_LO_IDX = 17;
   localparam int POS_W        = 6;
   localparam logic [7:0] NOP_KIND = 8'h01;
   localparam logic [7:0] EOL_KIND = 8'h00;

   // Strip map register indexes.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_0   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_64  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_128 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_192 = 2'd3;

   // Read address selection.
   localparam logic [1:0] RD_POS  = 2'd0;
   localparam logic [1:0] RD_POS1 = 2'd1;
   localparam logic [1:0] RD_EMIT = 2'd2;

   typedef struct packed {
      logic       load_en;
      logic       cnt_clr;
      logic       walk_init;
      logic       lim_frag;
      logic       emit_init;
      logic       kind_capture;
      logic       adv_pos;
      logic       strip_init;
      logic       strip_byte;
      logic       emit_load;
      logic       drop_load;
      logic [1:0] rd_sel;
   } tos_cmd_type;

   typedef struct packed {
      logic is_frag;
      logic bad_hdr;
      logic walk_more;
      logic opt_fits;
      logic kind_strip;
      logic strip_last;
      logic emit_last;
      logic out_free;
   } tos_status_type;

endpackage

// ===== rtl/tos_ram.sv =====
`timescale 1ns / 1ps

module tos_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/tos_datapath.sv =====
`timescale 1ns / 1ps

module tos_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [tos_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]                   csr_wdata,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [7:0]                    req_header_byte,
   input  logic                          req_later_fragment,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [7:0]                    rsp_out_byte,
   output logic                          rsp_out_last,
   output logic                          rsp_verdict_drop,
   input  tos_pkg::tos_cmd_type          cmd,
   output tos_pkg::tos_status_type       status
);

   import tos_pkg::*;

   logic [255:0]       map_ff, map_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               frag_ff, frag_in;
   logic [3:0]         doff_ff, doff_in;
   logic [15:0]        hc_ff, hc_in;
   logic               patch_ff, patch_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [7:0]         kind_ff, kind_in;
   logic [7:0]         rem_ff, rem_in;
   logic [LIM_W-1:0]   k_ff, k_in;
   logic [LIM_W-1:0]   lim_ff, lim_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_byte_ff, rsp_byte_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_drop_ff, rsp_drop_in;

   logic               load_fire;
   logic               store_ok;
   logic [5:0]         hlen;
   logic [7:0]         olen;
   logic [7:0]         rd_data;
   logic [BUF_AW-1:0]  rd_addr;
   logic               wr_en;
   logic [BUF_AW-1:0]  wr_addr;
   logic [7:0]         wr_data;
   logic [15:0]        m_old;
   logic [15:0]        m_new;
   logic [17:0]        csum_sum;
   logic [16:0]        csum_fold1;
   logic [15:0]        csum_fold2;
   logic [15:0]        hc_patched;
   logic [7:0]         emit_byte;

   assign load_fire = cmd.load_en && req_valid && req_ready;
   assign store_ok  = count_ff < CNT_W'(BUFFER_DEPTH);
   assign hlen      = {doff_ff, 2'b00};

   // Option length: single-byte kinds and zero length bytes take one byte.
   always_comb begin
      if ((kind_ff inside {EOL_KIND, NOP_KIND}) || (rd_data == 8'h00)) begin
         olen = 8'd1;
      end else begin
         olen = rd_data;
      end
   end

   always_comb begin
      case (cmd.rd_sel)
         RD_POS:  rd_addr = BUF_AW'(pos_ff);
         RD_POS1: rd_addr = BUF_AW'(pos_ff + POS_W'(1));
         RD_EMIT: rd_addr = BUF_AW'(k_ff);
         default: rd_addr = BUF_AW'(pos_ff);
      endcase
   end

   always_comb begin
      if (cmd.strip_byte) begin
         wr_en   = 1'b1;
         wr_addr = BUF_AW'(pos_ff);
         wr_data = NOP_KIND;
      end else begin
         wr_en   = load_fire && store_ok;
         wr_addr = BUF_AW'(count_ff);
         wr_data = req_header_byte;
      end
   end

   tos_ram #(
      .WIDTH (8),
      .DEPTH (BUFFER_DEPTH)
   ) u_buf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // One's-complement checksum patch for the byte being replaced by NOP.
   always_comb begin
      if (pos_ff[0]) begin
         m_old = {8'h00, rd_data};
         m_new = {8'h00, NOP_KIND};
      end else begin
         m_old = {rd_data, 8'h00};
         m_new = {NOP_KIND, 8'h00};
      end
      csum_sum   = {2'b00, ~hc_ff} + {2'b00, ~m_old} + {2'b00, m_new};
      csum_fold1 = 17'(csum_sum[15:0]) + 17'(csum_sum[17:16]);
      csum_fold2 = csum_fold1[15:0] + 16'(csum_fold1[16]);
      hc_patched = ~csum_fold2;
   end

   always_comb begin
      emit_byte = rd_data;
      if (patch_ff && (k_ff == LIM_W'(CKSUM_HI_IDX))) begin
         emit_byte = hc_ff[15:8];
      end else if (patch_ff && (k_ff == LIM_W'(CKSUM_LO_IDX))) begin
         emit_byte = hc_ff[7:0];
      end
   end

   always_comb begin
      map_in       = map_ff;
      count_in     = count_ff;
      frag_in      = frag_ff;
      doff_in      = doff_ff;
      hc_in        = hc_ff;
      patch_in     = patch_ff;
      pos_in       = pos_ff;
      kind_in      = kind_ff;
      rem_in       = rem_ff;
      k_in         = k_ff;
      lim_in       = lim_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_drop_in  = rsp_drop_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_MAP_0:   map_in[63:0]    = csr_wdata;
            CSR_MAP_64:  map_in[127:64]  = csr_wdata;
            CSR_MAP_128: map_in[191:128] = csr_wdata;
            CSR_MAP_192: map_in[255:192] = csr_wdata;
            default:     map_in          = map_ff;
         endcase
      end

      if (load_fire) begin
         if (count_ff == '0) begin
            frag_in = req_later_fragment;
         end
         if (store_ok) begin
            count_in = count_ff + CNT_W'(1);
            if (count_ff == CNT_W'(DOFF_IDX)) begin
               doff_in = req_header_byte[7:4];
            end
            if (count_ff == CNT_W'(CKSUM_HI_IDX)) begin
               hc_in[15:8] = req_header_byte;
            end
            if (count_ff == CNT_W'(CKSUM_LO_IDX)) begin
               hc_in[7:0] = req_header_byte;
            end
         end
      end

      if (cmd.cnt_clr) begin
         count_in = '0;
      end
      if (cmd.lim_frag) begin
         patch_in = 1'b0;
         if (int'(count_ff) > MAX_RESULTS) begin
            lim_in = LIM_W'(MAX_RESULTS);
         end else begin
            lim_in = LIM_W'(count_ff);
         end
      end
      if (cmd.walk_init) begin
         patch_in = 1'b1;
         pos_in   = POS_W'(HDR_MIN_LEN);
         lim_in   = LIM_W'(hlen);
      end
      if (cmd.kind_capture) begin
         kind_in = rd_data;
      end
      if (cmd.adv_pos) begin
         pos_in = POS_W'(pos_ff + POS_W'(olen));
      end
      if (cmd.strip_init) begin
         rem_in = olen;
      end
      if (cmd.strip_byte) begin
         hc_in  = hc_patched;
         pos_in = pos_ff + POS_W'(1);
         rem_in = rem_ff - 8'd1;
      end
      if (cmd.emit_init) begin
         k_in = '0;
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit_load) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = emit_byte;
         rsp_last_in  = (k_ff + LIM_W'(1)) == lim_ff;
         rsp_drop_in  = 1'b0;
         k_in         = k_ff + LIM_W'(1);
      end
      if (cmd.drop_load) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = 8'h00;
         rsp_last_in  = 1'b1;
         rsp_drop_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff       <= '0;
         count_ff     <= '0;
         frag_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         map_ff       <= map_in;
         count_ff     <= count_in;
         frag_ff      <= frag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      doff_ff     <= doff_in;
      hc_ff       <= hc_in;
      patch_ff    <= patch_in;
      pos_ff      <= pos_in;
      kind_ff     <= kind_in;
      rem_ff      <= rem_in;
      k_ff        <= k_in;
      lim_ff      <= lim_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      rsp_drop_ff <= rsp_drop_in;
   end

   assign status.is_frag    = frag_ff;
   assign status.bad_hdr    = (count_ff < CNT_W'(HDR_MIN_LEN))
                              || (hlen < 6'(HDR_MIN_LEN))
                              || (count_ff < CNT_W'(hlen));
   assign status.walk_more  = (7'(pos_ff) + 7'd1) < 7'(hlen);
   assign status.opt_fits   = (9'(pos_ff) + 9'(olen)) <= 9'(hlen);
   assign status.kind_strip = map_ff[kind_ff];
   assign status.strip_last = rem_ff == 8'd1;
   assign status.emit_last  = (k_ff + LIM_W'(1)) == lim_ff;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = rsp_byte_ff;
   assign rsp_out_last     = rsp_last_ff;
   assign rsp_verdict_drop = rsp_drop_ff;

endmodule

// ===== rtl/tos_ctrl.sv =====
`timescale 1ns / 1ps

module tos_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_final_byte,
   output logic                    req_ready,
   output tos_pkg::tos_cmd_type    cmd,
   input  tos_pkg::tos_status_type status
);

   import tos_pkg::*;

   localparam logic [3:0] ST_LOAD  = 4'd0;
   localparam logic [3:0] ST_CHECK = 4'd1;
   localparam logic [3:0] ST_WKIND = 4'd2;
   localparam logic [3:0] ST_WLEN  = 4'd3;
   localparam logic [3:0] ST_WEVAL = 4'd4;
   localparam logic [3:0] ST_SRD   = 4'd5;
   localparam logic [3:0] ST_SWR   = 4'd6;
   localparam logic [3:0] ST_ERD   = 4'd7;
   localparam logic [3:0] ST_ELD   = 4'd8;
   localparam logic [3:0] ST_DROP  = 4'd9;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.rd_sel = RD_POS;

      case (state_ff)
         ST_LOAD: begin
            req_ready   = 1'b1;
            cmd.load_en = 1'b1;
            if (req_valid && req_final_byte) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.cnt_clr = 1'b1;
            if (status.is_frag) begin
               cmd.lim_frag  = 1'b1;
               cmd.emit_init = 1'b1;
               state_in      = ST_ERD;
            end else if (status.bad_hdr) begin
               state_in = ST_DROP;
            end else begin
               cmd.walk_init = 1'b1;
               state_in      = ST_WKIND;
            end
         end
         ST_WKIND: begin
            if (status.walk_more) begin
               state_in = ST_WLEN;
            end else begin
               cmd.emit_init = 1'b1;
               state_in      = ST_ERD;
            end
         end
         ST_WLEN: begin
            cmd.kind_capture = 1'b1;
            cmd.rd_sel       = RD_POS1;
            state_in         = ST_WEVAL;
         end
         ST_WEVAL: begin
            if (!status.opt_fits) begin
               cmd.emit_init = 1'b1;
               state_in      = ST_ERD;
            end else if (status.kind_strip) begin
               cmd.strip_init = 1'b1;
               state_in       = ST_SRD;
            end else begin
               cmd.adv_pos = 1'b1;
               state_in    = ST_WKIND;
            end
         end
         ST_SRD: begin
            state_in = ST_SWR;
         end
         ST_SWR: begin
            cmd.strip_byte = 1'b1;
            if (status.strip_last) begin
               state_in = ST_WKIND;
            end else begin
               state_in = ST_SRD;
            end
         end
         ST_ERD: begin
            cmd.rd_sel = RD_EMIT;
            state_in   = ST_ELD;
         end
         ST_ELD: begin
            cmd.rd_sel = RD_EMIT;
            if (status.out_free) begin
               cmd.emit_load = 1'b1;
               if (status.emit_last) begin
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_ERD;
               end
            end
         end
         ST_DROP: begin
            if (status.out_free) begin
               cmd.drop_load = 1'b1;
               state_in      = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/tcp_option_stripper_top.sv =====
`timescale 1ns / 1ps

// TCP option stripper. Header bytes arrive one per transaction on the req_
// channel, starting at TCP byte 0, and while the block is loading are
// accepted one per cycle into a 64-byte buffer with one write port and one
// registered read port; bytes past the buffer depth are dropped. The
// transaction with req_final_byte set closes the header. The block then
// checks the length (data offset times four, at least 20 bytes, and all of
// it received), walks the options from byte 20 and overwrites every option
// whose kind has its bit set in the 256-bit strip map with NOP bytes,
// patching the TCP checksum incrementally for every byte it replaces.
// The patched header then leaves as one rsp_ transaction per byte, with
// rsp_out_last on the final one. A bad or short header yields a single
// transaction with rsp_verdict_drop set; a header whose first transaction
// carried req_later_fragment passes through unchanged (at most 64 bytes).
// For a good unfragmented header, processing runs in order: a check state,
// the option walk (kind, length and evaluation states for every option
// examined, a read and a write state for every stripped byte) until it
// reaches the end of the header or an option that runs past it, and the
// emit phase with a read and a load state per byte that advances while
// the receiver keeps up; a drop leaves from a drop state after the check.
// All reads go through the one read port of the header buffer. The next
// header can start loading as soon as the last result sits in the output
// register. The strip map (csr_index 0 to 3, 64 kinds each) should be
// written only while the block is idle.

module tcp_option_stripper_top (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          csr_we,
   input  logic [tos_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]                   csr_wdata,

   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_header_byte,
   input  logic                          req_final_byte,
   input  logic                          req_later_fragment,

   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [7:0]                    rsp_out_byte,
   output logic                          rsp_out_last,
   output logic                          rsp_verdict_drop
);

   import tos_pkg::*;

   // Commands from the sequencer and status back from the datapath.
   tos_cmd_type    cmd;
   tos_status_type status;

   tos_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_final_byte (req_final_byte),
      .req_ready      (req_ready),
      .cmd            (cmd),
      .status         (status)
   );

   tos_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_header_byte    (req_header_byte),
      .req_later_fragment (req_later_fragment),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_out_last       (rsp_out_last),
      .rsp_verdict_drop   (rsp_verdict_drop),
      .cmd                (cmd),
      .status             (status)
   );

endmodule

// ===== rtl/tos_checker.sv =====
`timescale 1ns / 1ps

module tos_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_final_byte,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_out_last,
   input logic       rsp_verdict_drop
);

   // A drop verdict is always a single, zero, final transaction.
   a_drop_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict_drop |-> rsp_out_last && (rsp_out_byte == 8'h00))
      else $error("drop transaction is not a lone final zero byte");

   // Once a header is closed, loading stops while it is processed.
   a_close_stalls : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_final_byte |=> !req_ready)
      else $error("input taken right after the closing byte");

   // A waiting result holds.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_out_last) && $stable(rsp_verdict_drop))
      else $error("pending result changed");

endmodule

bind tcp_option_stripper_top tos_checker u_tos_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_final_byte   (req_final_byte),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_out_byte     (rsp_out_byte),
   .rsp_out_last     (rsp_out_last),
   .rsp_verdict_drop (rsp_verdict_drop)
);
